/* rtl/core/eoe_rx_fragment_reassembly_macros.svh */
// assertion macros for the eoe receive fragment reassembly block
// no dependencies; included inside the modules that assert
`ifndef EOE_RX_FRAGMENT_REASSEMBLY_MACROS_SVH
`define EOE_RX_FRAGMENT_REASSEMBLY_MACROS_SVH

// same-cycle implication
`define EOERX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eoerx assertion failed");

// next-cycle implication
`define EOERX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eoerx assertion failed");

`endif

/* rtl/core/eoerx_pkg.sv */
// shared types, codes and helpers of the eoe receive fragment reassembly block
// no dependencies
`timescale 1ns / 1ps

package eoerx_pkg;

   localparam logic [2:0] STATUS_ACCEPTED     = 3'd0;
   localparam logic [2:0] STATUS_COMPLETE     = 3'd1;
   localparam logic [2:0] STATUS_DROP_TYPE    = 3'd2;
   localparam logic [2:0] STATUS_DROP_NOFRAME = 3'd3;
   localparam logic [2:0] STATUS_ERR_TRANSFER = 3'd4;
   localparam logic [2:0] STATUS_ERR_SEQUENCE = 3'd5;

   localparam logic [3:0]  EOE_PROTOCOL        = 4'h2;
   localparam logic [3:0]  FRAME_TYPE_FRAGMENT = 4'h0;
   localparam logic [5:0]  FIRST_FRAGMENT      = 6'd0;
   localparam int          BLOCK_SHIFT         = 5;
   localparam logic [11:0] HDR_BYTES           = 12'd4;
   localparam logic [11:0] HDR_STAMP_BYTES     = 12'd8;
   localparam logic [31:0] COUNT_MAX           = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        transfer_ok;
      logic        fetch_ok;
      logic [3:0]  mailbox_protocol;
      logic [15:0] header_low;
      logic [15:0] header_high;
      logic [11:0] received_size;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [10:0] payload_offset;
      logic [10:0] payload_length;
      logic [10:0] frame_length;
      logic        old_frame_discarded;
      logic [31:0] error_total;
      logic [31:0] drop_total;
      logic [31:0] packet_total;
      logic [31:0] byte_total;
   } rsp_type;

   typedef struct packed {
      logic        frame_open;
      logic [10:0] fill_offset;
      logic [10:0] frame_capacity;
      logic [5:0]  expected_fragment;
      logic [31:0] error_count;
      logic [31:0] drop_count;
      logic [31:0] packet_count;
      logic [31:0] byte_count;
   } state_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [10:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + 33'(b);
      return sum[32] ? COUNT_MAX : sum[31:0];
   endfunction

endpackage

/* rtl/core/eoerx_if.sv */
// request and response channel interfaces of the eoe receive fragment reassembly block
// depends on eoerx_pkg
`timescale 1ns / 1ps

interface eoerx_req_if;
   import eoerx_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface eoerx_rsp_if;
   import eoerx_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/eoerx_step.sv */
// header check and frame bookkeeping for one mailbox reply, purely combinational
// depends on eoerx_pkg
`timescale 1ns / 1ps

module eoerx_step (
   input  eoerx_pkg::req_type   item,
   input  eoerx_pkg::state_type st,
   output eoerx_pkg::state_type st_next,
   output eoerx_pkg::rsp_type   res
);
   import eoerx_pkg::*;

   logic        last_frag;
   logic        stamp;
   logic [5:0]  frag;
   logic [10:0] blk;
   logic [11:0] hdr_len;
   logic [11:0] dsize;
   logic [12:0] reach;
   logic [10:0] new_fill;
   logic        ok;

   always_comb begin
      last_frag = item.header_low[8];
      stamp     = item.header_low[9];
      frag      = item.header_high[5:0];
      blk       = 11'(item.header_high[11:6]) << BLOCK_SHIFT;
      hdr_len   = stamp ? HDR_STAMP_BYTES : HDR_BYTES;
      dsize     = item.received_size - hdr_len;
      reach     = 13'(blk) + 13'(dsize);
      new_fill  = '0;
      ok        = 1'b0;
      st_next   = st;

      res                     = '0;
      res.status              = STATUS_ACCEPTED;

      if (!item.transfer_ok || !item.fetch_ok || item.mailbox_protocol != EOE_PROTOCOL) begin
         st_next.error_count = sat_add(st.error_count, 11'd1);
         res.status          = STATUS_ERR_TRANSFER;
      end else if (item.header_low[3:0] != FRAME_TYPE_FRAGMENT) begin
         st_next.drop_count = sat_add(st.drop_count, 11'd1);
         res.status         = STATUS_DROP_TYPE;
      end else if (item.received_size < hdr_len) begin
         st_next.error_count = sat_add(st.error_count, 11'd1);
         res.status          = STATUS_ERR_TRANSFER;
      end else if (frag == FIRST_FRAGMENT) begin
         res.old_frame_discarded = st.frame_open;
         st_next.frame_open      = 1'b0;
         if (dsize > 12'(blk)) begin
            st_next.error_count = sat_add(st.error_count, 11'd1);
            res.status          = STATUS_ERR_SEQUENCE;
         end else begin
            st_next.frame_open        = 1'b1;
            st_next.fill_offset       = '0;
            st_next.frame_capacity    = blk;
            st_next.expected_fragment = '0;
            ok                        = 1'b1;
         end
      end else if (!st.frame_open) begin
         st_next.drop_count = sat_add(st.drop_count, 11'd1);
         res.status         = STATUS_DROP_NOFRAME;
      end else if (blk != st.fill_offset || reach > 13'(st.frame_capacity) ||
                   frag != st.expected_fragment) begin
         st_next.frame_open  = 1'b0;
         st_next.error_count = sat_add(st.error_count, 11'd1);
         res.status          = STATUS_ERR_SEQUENCE;
      end else begin
         ok = 1'b1;
      end

      if (ok) begin
         new_fill            = st_next.fill_offset + dsize[10:0];
         res.payload_offset  = st_next.fill_offset;
         res.payload_length  = dsize[10:0];
         st_next.fill_offset = new_fill;
         if (last_frag) begin
            st_next.packet_count = sat_add(st.packet_count, 11'd1);
            st_next.byte_count   = sat_add(st.byte_count, new_fill);
            st_next.frame_open   = 1'b0;
            res.frame_length     = new_fill;
            res.status           = STATUS_COMPLETE;
         end else begin
            st_next.expected_fragment = st_next.expected_fragment + 6'd1;
            res.status                = STATUS_ACCEPTED;
         end
      end

      res.error_total  = st_next.error_count;
      res.drop_total   = st_next.drop_count;
      res.packet_total = st_next.packet_count;
      res.byte_total   = st_next.byte_count;
   end

endmodule

/* rtl/core/eoe_rx_fragment_reassembly.sv */
// top level of the eoe receive fragment reassembly block
// depends on eoerx_pkg, eoerx_if, eoerx_step and the macros header
`timescale 1ns / 1ps

// Takes one fetched mailbox reply per word and returns one status word per reply: fragment
// placement (offset and length in the frame buffer), frame length on completion, and the
// saturating error, drop, packet and byte counters after that reply. Payload bytes are not
// moved here. A reply is held in an input register and evaluated against the frame state
// into the response register once that register is free or being taken, so a new reply can
// be accepted every cycle while the response is not stalled. A stalled response holds the
// input register, which in turn holds off the next reply.
module eoe_rx_fragment_reassembly (
   input logic        clock,
   input logic        reset,
   eoerx_req_if.sink  req_chan,
   eoerx_rsp_if.source rsp_chan
);
   import eoerx_pkg::*;
   `include "eoe_rx_fragment_reassembly_macros.svh"

   req_type   item_ff, item_in;
   logic      item_valid_ff, item_valid_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type state_ff, state_in;

   state_type st_next;
   rsp_type   res;
   logic      advance;
   logic      take;

   eoerx_step u_step (
      .item    (item_ff),
      .st      (state_ff),
      .st_next (st_next),
      .res     (res)
   );

   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   always_comb begin
      item_in       = take ? req_chan.data : item_ff;
      item_valid_in = take || (item_valid_ff && !advance);
      rsp_in        = advance ? res : rsp_ff;
      rsp_valid_in  = advance || (rsp_valid_ff && !rsp_chan.ready);
      state_in      = advance ? st_next : state_ff;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   `EOERX_ASSERT_NEXT(a_err_monotonic, clock, reset, 1'b1, state_ff.error_count >= $past(state_ff.error_count))
   `EOERX_ASSERT_NOW(a_fill_in_capacity, clock, reset, state_ff.frame_open, state_ff.fill_offset <= state_ff.frame_capacity)
   `EOERX_ASSERT_NOW(a_no_len_on_reject, clock, reset, rsp_valid_ff && rsp_ff.status != STATUS_ACCEPTED && rsp_ff.status != STATUS_COMPLETE, rsp_ff.payload_length == '0)
   `EOERX_ASSERT_NEXT(a_stalled_item_held, clock, reset, item_valid_ff && !advance, item_valid_ff)

endmodule
